// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_COMB(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: check failed");
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define CHK_COMB(lbl, clk, rstn, prop)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/nrdiv_pkg.sv =====
// ----------------------------------------------------------------------------
// nrdiv_pkg
// shared types, commands and constants of the reciprocal divider
// ----------------------------------------------------------------------------
package nrdiv_pkg;

    localparam int unsigned MAX_ITER  = 16;
    localparam int unsigned ITER_W    = $clog2(MAX_ITER);
    localparam int unsigned SALT_W    = 64;
    localparam int unsigned MOD_BITS  = 8;
    localparam int unsigned MOD_STEPS = SALT_W / MOD_BITS;
    localparam int unsigned MOD_W     = $clog2(MOD_STEPS);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FELL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_D_XLO,
        MUL_D_XHI,
        MUL_PLO_XLO,
        MUL_PLO_XHI,
        MUL_PHI_XLO,
        MUL_D_YLO,
        MUL_D_YHI,
        MUL_XLO_A,
        MUL_XHI_A,
        MUL_Q_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI
    } acc_op_t;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_ZERO,
        RES_SHORT,
        RES_FAIL,
        RES_QUOT,
        RES_REM,
        RES_FIX
    } res_op_t;

    typedef enum logic [1:0] {
        X_HOLD,
        X_INIT,
        X_NEXT,
        X_INC_IF
    } x_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MOD,
        S_CLASS,
        S_DECIDE,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_M7,
        S_M8,
        S_SUB,
        S_CHK,
        S_C1,
        S_C2,
        S_C3,
        S_C4,
        S_Q1,
        S_Q2,
        S_Q3,
        S_Q4,
        S_QD1,
        S_QD2,
        S_FIX,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mod_step;
        logic     classify;
        logic     latch_p;
        logic     sub_t;
        x_op_t    x_op;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        res_op_t  res_op;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic d_zero;
        logic wide;
        logic fell;
        logic conv;
    } stat_t;

    function automatic logic [5:0] bit_len(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== design/nrdiv_ctrl.sv =====
// ----------------------------------------------------------------------------
// nrdiv_ctrl
// sequencer for salt reduction, newton steps, corrections and output
// ----------------------------------------------------------------------------
module nrdiv_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  nrdiv_pkg::stat_t    stat,
    output nrdiv_pkg::cmd_t     cmd
);

    nrdiv_pkg::state_t                 state_reg, state_next;
    logic [nrdiv_pkg::MOD_W-1:0]       mod_cnt_reg, mod_cnt_next;
    logic [nrdiv_pkg::ITER_W-1:0]      iter_reg, iter_next;
    logic                              out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= nrdiv_pkg::S_IDLE;
            mod_cnt_reg   <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mod_cnt_reg   <= mod_cnt_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == nrdiv_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        mod_cnt_next   = mod_cnt_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            nrdiv_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load     = 1'b1;
                    mod_cnt_next = '0;
                    state_next   = nrdiv_pkg::S_MOD;
                end
            end
            nrdiv_pkg::S_MOD: begin
                cmd.mod_step = 1'b1;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == nrdiv_pkg::MOD_W'(nrdiv_pkg::MOD_STEPS - 1)) begin
                    state_next = nrdiv_pkg::S_CLASS;
                end
            end
            nrdiv_pkg::S_CLASS: begin
                cmd.classify = 1'b1;
                state_next   = nrdiv_pkg::S_DECIDE;
            end
            nrdiv_pkg::S_DECIDE: begin
                priority if (stat.d_zero) begin
                    cmd.res_op = nrdiv_pkg::RES_ZERO;
                    state_next = nrdiv_pkg::S_FINISH;
                end else if (stat.wide) begin
                    cmd.res_op = nrdiv_pkg::RES_SHORT;
                    state_next = nrdiv_pkg::S_FINISH;
                end else begin
                    cmd.x_op   = nrdiv_pkg::X_INIT;
                    iter_next  = '0;
                    state_next = nrdiv_pkg::S_M1;
                end
            end
            nrdiv_pkg::S_M1: begin
                cmd.mul_sel = nrdiv_pkg::MUL_D_XLO;
                state_next  = nrdiv_pkg::S_M2;
            end
            nrdiv_pkg::S_M2: begin
                cmd.mul_sel = nrdiv_pkg::MUL_D_XHI;
                cmd.acc_op  = nrdiv_pkg::ACC_LOAD;
                state_next  = nrdiv_pkg::S_M3;
            end
            nrdiv_pkg::S_M3: begin
                cmd.acc_op = nrdiv_pkg::ACC_ADD_HI;
                state_next = nrdiv_pkg::S_M4;
            end
            nrdiv_pkg::S_M4: begin
                cmd.latch_p = 1'b1;
                state_next  = nrdiv_pkg::S_M5;
            end
            nrdiv_pkg::S_M5: begin
                cmd.mul_sel = nrdiv_pkg::MUL_PLO_XLO;
                state_next  = nrdiv_pkg::S_M6;
            end
            nrdiv_pkg::S_M6: begin
                cmd.mul_sel = nrdiv_pkg::MUL_PLO_XHI;
                cmd.acc_op  = nrdiv_pkg::ACC_LOAD;
                state_next  = nrdiv_pkg::S_M7;
            end
            nrdiv_pkg::S_M7: begin
                cmd.mul_sel = nrdiv_pkg::MUL_PHI_XLO;
                cmd.acc_op  = nrdiv_pkg::ACC_ADD_HI;
                state_next  = nrdiv_pkg::S_M8;
            end
            nrdiv_pkg::S_M8: begin
                cmd.acc_op = nrdiv_pkg::ACC_ADD_HI;
                state_next = nrdiv_pkg::S_SUB;
            end
            nrdiv_pkg::S_SUB: begin
                cmd.sub_t  = 1'b1;
                state_next = nrdiv_pkg::S_CHK;
            end
            nrdiv_pkg::S_CHK: begin
                priority if (stat.fell) begin
                    cmd.res_op = nrdiv_pkg::RES_FAIL;
                    state_next = nrdiv_pkg::S_FINISH;
                end else if (stat.conv) begin
                    state_next = nrdiv_pkg::S_C1;
                end else if (iter_reg == nrdiv_pkg::ITER_W'(nrdiv_pkg::MAX_ITER - 1)) begin
                    cmd.res_op = nrdiv_pkg::RES_FAIL;
                    state_next = nrdiv_pkg::S_FINISH;
                end else begin
                    cmd.x_op   = nrdiv_pkg::X_NEXT;
                    iter_next  = iter_reg + 1'b1;
                    state_next = nrdiv_pkg::S_M1;
                end
            end
            nrdiv_pkg::S_C1: begin
                cmd.mul_sel = nrdiv_pkg::MUL_D_YLO;
                state_next  = nrdiv_pkg::S_C2;
            end
            nrdiv_pkg::S_C2: begin
                cmd.mul_sel = nrdiv_pkg::MUL_D_YHI;
                cmd.acc_op  = nrdiv_pkg::ACC_LOAD;
                state_next  = nrdiv_pkg::S_C3;
            end
            nrdiv_pkg::S_C3: begin
                cmd.acc_op = nrdiv_pkg::ACC_ADD_HI;
                state_next = nrdiv_pkg::S_C4;
            end
            nrdiv_pkg::S_C4: begin
                cmd.x_op   = nrdiv_pkg::X_INC_IF;
                state_next = nrdiv_pkg::S_Q1;
            end
            nrdiv_pkg::S_Q1: begin
                cmd.mul_sel = nrdiv_pkg::MUL_XLO_A;
                state_next  = nrdiv_pkg::S_Q2;
            end
            nrdiv_pkg::S_Q2: begin
                cmd.mul_sel = nrdiv_pkg::MUL_XHI_A;
                cmd.acc_op  = nrdiv_pkg::ACC_LOAD;
                state_next  = nrdiv_pkg::S_Q3;
            end
            nrdiv_pkg::S_Q3: begin
                cmd.acc_op = nrdiv_pkg::ACC_ADD_HI;
                state_next = nrdiv_pkg::S_Q4;
            end
            nrdiv_pkg::S_Q4: begin
                cmd.res_op = nrdiv_pkg::RES_QUOT;
                state_next = nrdiv_pkg::S_QD1;
            end
            nrdiv_pkg::S_QD1: begin
                cmd.mul_sel = nrdiv_pkg::MUL_Q_D;
                state_next  = nrdiv_pkg::S_QD2;
            end
            nrdiv_pkg::S_QD2: begin
                cmd.res_op = nrdiv_pkg::RES_REM;
                state_next = nrdiv_pkg::S_FIX;
            end
            nrdiv_pkg::S_FIX: begin
                cmd.res_op = nrdiv_pkg::RES_FIX;
                state_next = nrdiv_pkg::S_FINISH;
            end
            nrdiv_pkg::S_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = nrdiv_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = nrdiv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/nrdiv_dp.sv =====
// ----------------------------------------------------------------------------
// nrdiv_dp
// datapath: salt reduction, shared 32x32 multiplier, accumulator, results
// ----------------------------------------------------------------------------
module nrdiv_dp (
    input  logic                aclk,
    input  logic [31:0]         in_dividend,
    input  logic [31:0]         in_divisor,
    input  logic [63:0]         in_salt,
    input  nrdiv_pkg::cmd_t     cmd,
    output nrdiv_pkg::stat_t    stat,
    output logic [31:0]         out_quotient,
    output logic [31:0]         out_remainder,
    output logic [1:0]          out_status
);

    logic [31:0]                    a_reg;
    logic [31:0]                    d_reg;
    logic [nrdiv_pkg::SALT_W-1:0]   salt_reg;
    logic [5:0]                     n_reg;
    logic [5:0]                     m_reg;
    logic [5:0]                     mod_rem_reg;
    logic [5:0]                     k_reg;
    logic [5:0]                     r_reg;
    logic [63:0]                    x_reg;
    logic [63:0]                    p_reg;
    logic [63:0]                    prod_reg;
    logic [63:0]                    acc_reg;
    logic [63:0]                    t_reg;
    logic [31:0]                    q_reg;
    logic [31:0]                    rem_reg;
    nrdiv_pkg::status_t             st_reg;
    logic [31:0]                    out_q_reg;
    logic [31:0]                    out_rem_reg;
    nrdiv_pkg::status_t             out_st_reg;

    logic [5:0]                     mod_rem_next;
    logic [5:0]                     n_in;
    logic [31:0]                    op_a;
    logic [31:0]                    op_b;
    logic [63:0]                    y;
    logic [63:0]                    x1;
    logic [63:0]                    base;

    assign n_in = nrdiv_pkg::bit_len(in_dividend);
    assign y    = x_reg + 64'd1;
    assign x1   = t_reg >> k_reg;
    assign base = 64'd1 << k_reg;

    assign stat.d_zero = (d_reg == '0);
    assign stat.wide   = (r_reg >= k_reg);
    assign stat.fell   = (x1 < x_reg);
    assign stat.conv   = (x1 == x_reg);

    // restoring reduction, one salt byte per cycle, msb first
    always_comb begin
        logic [6:0] mv;
        logic [5:0] mr;
        mr = mod_rem_reg;
        for (int i = 0; i < nrdiv_pkg::MOD_BITS; i++) begin
            mv = {mr, salt_reg[nrdiv_pkg::SALT_W - 1 - i]};
            if (mv >= {1'b0, m_reg}) begin
                mv = mv - {1'b0, m_reg};
            end
            mr = mv[5:0];
        end
        mod_rem_next = mr;
    end

    always_comb begin
        op_a = d_reg;
        op_b = x_reg[31:0];
        unique case (cmd.mul_sel)
            nrdiv_pkg::MUL_D_XLO: begin
                op_a = d_reg;
                op_b = x_reg[31:0];
            end
            nrdiv_pkg::MUL_D_XHI: begin
                op_a = d_reg;
                op_b = x_reg[63:32];
            end
            nrdiv_pkg::MUL_PLO_XLO: begin
                op_a = p_reg[31:0];
                op_b = x_reg[31:0];
            end
            nrdiv_pkg::MUL_PLO_XHI: begin
                op_a = p_reg[31:0];
                op_b = x_reg[63:32];
            end
            nrdiv_pkg::MUL_PHI_XLO: begin
                op_a = p_reg[63:32];
                op_b = x_reg[31:0];
            end
            nrdiv_pkg::MUL_D_YLO: begin
                op_a = d_reg;
                op_b = y[31:0];
            end
            nrdiv_pkg::MUL_D_YHI: begin
                op_a = d_reg;
                op_b = y[63:32];
            end
            nrdiv_pkg::MUL_XLO_A: begin
                op_a = x_reg[31:0];
                op_b = a_reg;
            end
            nrdiv_pkg::MUL_XHI_A: begin
                op_a = x_reg[63:32];
                op_b = a_reg;
            end
            nrdiv_pkg::MUL_Q_D: begin
                op_a = q_reg;
                op_b = d_reg;
            end
            nrdiv_pkg::MUL_NONE: begin
                op_a = d_reg;
                op_b = x_reg[31:0];
            end
            default: begin
                op_a = d_reg;
                op_b = x_reg[31:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg       <= in_dividend;
            d_reg       <= in_divisor;
            salt_reg    <= in_salt;
            n_reg       <= n_in;
            m_reg       <= 6'd33 - n_in;
            mod_rem_reg <= '0;
        end
        if (cmd.mod_step) begin
            mod_rem_reg <= mod_rem_next;
            salt_reg    <= {salt_reg[nrdiv_pkg::SALT_W-nrdiv_pkg::MOD_BITS-1:0],
                            nrdiv_pkg::MOD_BITS'(0)};
        end
        if (cmd.classify) begin
            k_reg <= n_reg + mod_rem_reg;
            r_reg <= nrdiv_pkg::bit_len(d_reg);
        end
        if (cmd.mul_sel != nrdiv_pkg::MUL_NONE) begin
            prod_reg <= op_a * op_b;
        end
        unique case (cmd.acc_op)
            nrdiv_pkg::ACC_LOAD:   acc_reg <= prod_reg;
            nrdiv_pkg::ACC_ADD_HI: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            nrdiv_pkg::ACC_HOLD:   acc_reg <= acc_reg;
            default:               acc_reg <= acc_reg;
        endcase
        if (cmd.latch_p) begin
            p_reg <= acc_reg;
        end
        if (cmd.sub_t) begin
            t_reg <= (x_reg << (k_reg + 6'd1)) - acc_reg;
        end
        unique case (cmd.x_op)
            nrdiv_pkg::X_INIT:   x_reg <= 64'd1 << (k_reg - r_reg);
            nrdiv_pkg::X_NEXT:   x_reg <= x1;
            nrdiv_pkg::X_INC_IF: begin
                if (base > acc_reg) begin
                    x_reg <= y;
                end
            end
            nrdiv_pkg::X_HOLD:   x_reg <= x_reg;
            default:             x_reg <= x_reg;
        endcase
        unique case (cmd.res_op)
            nrdiv_pkg::RES_ZERO: begin
                q_reg   <= '0;
                rem_reg <= '0;
                st_reg  <= nrdiv_pkg::ST_ZERO;
            end
            nrdiv_pkg::RES_FAIL: begin
                q_reg   <= '0;
                rem_reg <= '0;
                st_reg  <= nrdiv_pkg::ST_FELL;
            end
            nrdiv_pkg::RES_SHORT: begin
                if ((r_reg != k_reg) || (a_reg < d_reg)) begin
                    q_reg   <= '0;
                    rem_reg <= a_reg;
                end else begin
                    q_reg   <= 32'd1;
                    rem_reg <= a_reg - d_reg;
                end
                st_reg <= nrdiv_pkg::ST_OK;
            end
            nrdiv_pkg::RES_QUOT: begin
                q_reg <= 32'(acc_reg >> k_reg);
            end
            nrdiv_pkg::RES_REM: begin
                rem_reg <= a_reg - prod_reg[31:0];
            end
            nrdiv_pkg::RES_FIX: begin
                if (rem_reg >= d_reg) begin
                    q_reg   <= q_reg + 32'd1;
                    rem_reg <= rem_reg - d_reg;
                end
                st_reg <= nrdiv_pkg::ST_OK;
            end
            nrdiv_pkg::RES_HOLD: begin
                q_reg <= q_reg;
            end
            default: begin
                q_reg <= q_reg;
            end
        endcase
        if (cmd.out_load) begin
            out_q_reg   <= q_reg;
            out_rem_reg <= rem_reg;
            out_st_reg  <= st_reg;
        end
    end

    assign out_quotient  = out_q_reg;
    assign out_remainder = out_rem_reg;
    assign out_status    = out_st_reg;

endmodule

// ===== design/newton_reciprocal_integer_divider_top.sv =====
// ----------------------------------------------------------------------------
// newton_reciprocal_integer_divider_top
// 32-bit integer divider by newton-raphson reciprocal with a salted base
// ----------------------------------------------------------------------------
// input item on s_: dividend, divisor and salt, taken when tvalid and tready
// are high. result item on m_: quotient and remainder in tdata, status in
// tuser (ok, divisor zero, iteration fell or ran out of steps).
// one item is worked on at a time; s_tready is high only while idle.
// every item first goes through the salt reduction. a zero divisor or a
// divisor at least as wide as the base then goes straight to the result, as
// does an iteration that falls or runs out of steps; otherwise up to 16
// newton steps, each on the single shared 32x32 multiplier and its
// accumulator, are followed by the correction, quotient and remainder steps.
// the next item can be taken in the cycle after the result is registered.
// the result sits in an output register; while the receiver stalls a
// following item is still accepted and computed, and it waits in the last
// state until the output register is free.
// reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module newton_reciprocal_integer_divider_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [127:0]    s_tdata,   // dividend[31:0], divisor[63:32], salt[127:64]
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata,   // quotient[31:0], remainder[63:32]
    output logic [1:0]      m_tuser    // status[1:0]
);

    nrdiv_pkg::cmd_t    cmd;
    nrdiv_pkg::stat_t   stat;
    logic [31:0]        quotient;
    logic [31:0]        remainder;

    nrdiv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nrdiv_dp u_dp (
        .aclk          (aclk),
        .in_dividend   (s_tdata[31:0]),
        .in_divisor    (s_tdata[63:32]),
        .in_salt       (s_tdata[127:64]),
        .cmd           (cmd),
        .stat          (stat),
        .out_quotient  (quotient),
        .out_remainder (remainder),
        .out_status    (m_tuser)
    );

    assign m_tdata = {remainder, quotient};

    `CHK_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `CHK_COMB(a_fail_clears_data, aclk, aresetn, (m_tvalid && (m_tuser != nrdiv_pkg::ST_OK)) |-> (m_tdata == '0))
    `CHK_COMB(a_step_only_rising, aclk, aresetn, (cmd.x_op == nrdiv_pkg::X_NEXT) |-> (!stat.fell && !stat.conv))

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the newton-raphson reciprocal divider: a queue of
// directed and random items feeds a stream driver, each accepted item is
// divided by a local reciprocal predictor, and a monitor compares every
// result item field by field while both sides idle and stall at random
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS   = 730;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES  = 250;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct {
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic [63:0] salt;
        bit          drain;
    } div_item_t;

    typedef struct {
        logic [31:0]         quotient;
        logic [31:0]         remainder;
        nrdiv_pkg::status_t  status;
    } quot_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [127:0]   s_tdata = '0;   // dividend[31:0], divisor[63:32], salt[127:64]
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [63:0]    m_tdata;        // quotient[31:0], remainder[63:32]
    logic [1:0]     m_tuser;        // status[1:0]

    div_item_t      pending[$];
    quot_t          quot_fifo[$];
    div_item_t      cur_item;
    int unsigned    n_predicted = 0;
    int unsigned    n_checked = 0;
    int unsigned    n_errors = 0;
    int unsigned    n_ok = 0;
    int unsigned    n_zero = 0;
    int unsigned    n_fell = 0;
    int unsigned    n_drains = 0;
    int unsigned    send_gap = 0;
    int unsigned    recv_stall = 0;
    int unsigned    quiet_cycles = 0;
    logic           calm = 1'b0;
    logic           item_busy;

    newton_reciprocal_integer_divider_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever begin
            #2 aclk = ~aclk;
        end
    end

    function automatic int unsigned sig_bits(input logic [31:0] v);
        int unsigned w;
        w = 0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                w = i + 1;
            end
        end
        return w;
    endfunction

    function automatic quot_t divide_by_reciprocal(input div_item_t it);
        quot_t       res;
        int unsigned n_a;
        int unsigned n_d;
        int unsigned k;
        logic [63:0] x;
        logic [63:0] x_nxt;
        logic [63:0] dd;
        logic [63:0] base;
        logic [31:0] q;
        logic [31:0] rem;
        bit          settled;
        res.status = nrdiv_pkg::ST_OK;
        q = '0;
        rem = '0;
        settled = 1'b0;
        n_a = sig_bits(it.dividend);
        n_d = sig_bits(it.divisor);
        k = n_a + int'(it.salt % 64'(33 - n_a));
        base = 64'd1 << k;
        dd = 64'(it.divisor);
        if (it.divisor == 0) begin
            res.status = nrdiv_pkg::ST_ZERO;
        end else if (n_d >= k) begin
            if (n_d != k || it.dividend < it.divisor) begin
                rem = it.dividend;
            end else begin
                q = 32'd1;
                rem = it.dividend - it.divisor;
            end
        end else begin
            x = 64'd1 << (k - n_d);
            for (int i = 0; i < nrdiv_pkg::MAX_ITER; i++) begin
                x_nxt = ((x << (k + 1)) - dd * x * x) >> k;
                if (x_nxt < x) begin
                    break;
                end
                if (x_nxt == x) begin
                    settled = 1'b1;
                    break;
                end
                x = x_nxt;
            end
            if (!settled) begin
                res.status = nrdiv_pkg::ST_FELL;
            end else begin
                if (base > dd * (x + 64'd1)) begin
                    x = x + 64'd1;
                end
                q = 32'((x * 64'(it.dividend)) >> k);
                rem = it.dividend - q * it.divisor;
                if (rem >= it.divisor) begin
                    q = q + 32'd1;
                    rem = rem - it.divisor;
                end
            end
        end
        if (res.status != nrdiv_pkg::ST_OK) begin
            q = '0;
            rem = '0;
        end
        res.quotient = q;
        res.remainder = rem;
        return res;
    endfunction

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int unsigned gap_len(input logic quiet);
        int unsigned pick;
        if (quiet) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            return 0;
        end
        if (pick < 95) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input logic [31:0] a, input logic [31:0] d,
                            input logic [63:0] salt, input bit drain);
        div_item_t it;
        it.dividend = a;
        it.divisor = d;
        it.salt = salt;
        it.drain = drain;
        pending.push_back(it);
    endtask

    task automatic report(input string what, input logic [31:0] want,
                          input logic [31:0] got);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("mismatch on result %0d: %s expected %h got %h",
                     n_checked, what, want, got);
        end
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                quot_fifo.push_back(divide_by_reciprocal(cur_item));
                n_predicted++;
                item_busy = 1'b0;
            end else begin
                item_busy = s_tvalid;
            end
            calm <= ((n_predicted / 120) % 3) == 2;
            if (!item_busy) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0 &&
                             (!pending[0].drain || n_checked == n_predicted)) begin
                    cur_item = pending.pop_front();
                    if (cur_item.drain) begin
                        n_drains++;
                    end
                    s_tdata <= {cur_item.salt, cur_item.divisor, cur_item.dividend};
                    s_tvalid <= 1'b1;
                    send_gap = gap_len(calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        quot_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (quot_fifo.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("unexpected result: quotient %h remainder %h status %0d",
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                    end
                end else begin
                    want = quot_fifo.pop_front();
                    if (m_tdata[31:0] !== want.quotient) begin
                        report("quotient", want.quotient, m_tdata[31:0]);
                    end
                    if (m_tdata[63:32] !== want.remainder) begin
                        report("remainder", want.remainder, m_tdata[63:32]);
                    end
                    if (m_tuser !== want.status) begin
                        report("status", 32'(want.status), 32'(m_tuser));
                    end
                    case (want.status)
                        nrdiv_pkg::ST_OK: begin
                            n_ok++;
                        end
                        nrdiv_pkg::ST_ZERO: begin
                            n_zero++;
                        end
                        default: begin
                            n_fell++;
                        end
                    endcase
                    n_checked <= n_checked + 1;
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                recv_stall = gap_len(calm);
                m_tready <= (recv_stall == 0);
                if (recv_stall != 0) begin
                    recv_stall--;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, n_predicted - n_checked);
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] a;
        logic [31:0] d;
        logic [63:0] salt;
        int unsigned pick;

        // zero divisor
        add_item(32'h0000_0000, 32'h0000_0000, 64'd0, 1'b0);
        add_item(32'hFFFF_FFFF, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // divisor wider than the base
        add_item(32'h0000_0000, 32'h0000_0001, 64'd0, 1'b0);
        add_item(32'h0000_0000, 32'hFFFF_FFFF, 64'd0, 1'b0);
        add_item(32'h0000_0005, 32'h0000_0100, 64'd0, 1'b0);
        // divisor exactly as wide as the base
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 1'b0);
        add_item(32'h8000_0000, 32'hFFFF_FFFF, 64'd0, 1'b0);
        add_item(32'h0000_0001, 32'h0000_0001, 64'd0, 1'b0);
        add_item(32'h0000_0007, 32'h0000_0006, 64'd0, 1'b0);
        add_item(32'h0000_0007, 32'h0000_0007, 64'd0, 1'b0);
        // extremes of base and operands, mostly on the full newton path
        add_item(32'hFFFF_FFFF, 32'h0000_0001, 64'd0, 1'b0);
        add_item(32'h0000_0001, 32'h0000_0001, 64'd31, 1'b0);
        add_item(32'hFFFF_FFFF, 32'h8000_0000, 64'd0, 1'b0);
        add_item(32'hFFFF_FFFF, 32'h0000_0003, 64'd0, 1'b0);
        add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'd1, 1'b0);
        add_item(32'h0000_03E8, 32'h0000_0003, 64'd0, 1'b0);
        add_item(32'h0000_03E8, 32'h0000_0003, 64'd5, 1'b0);
        add_item(32'h0000_0064, 32'h0000_0007, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(32'h1234_5678, 32'h0001_0000, 64'd7, 1'b0);
        add_item(32'hDEAD_BEEF, 32'h0000_FFFF, 64'h8000_0000_0000_0000, 1'b0);
        add_item(32'h0000_00C8, 32'h0000_00C7, 64'd0, 1'b0);
        add_item(32'h0000_0001, 32'h0000_0000, 64'h5555_5555_AAAA_AAAA, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            a = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 9) == 0) begin
                a = $urandom;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                d = '0;
            end else if (pick == 1) begin
                d = 32'd1 << $urandom_range(0, 31);
            end else if (pick == 2) begin
                d = a;
            end else if (pick < 6) begin
                d = $urandom_range(1, 15);
            end else begin
                d = $urandom >> $urandom_range(0, 31);
            end
            if ($urandom_range(0, 3) == 0) begin
                salt = 64'($urandom_range(0, 40));
            end else begin
                salt = {$urandom, $urandom};
            end
            add_item(a, d, salt, (i % 200) == 0);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid || n_checked != n_predicted) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        n_errors += quot_fifo.size();

        $display("divisions checked: %0d (ok %0d, zero divisor %0d, failed iteration %0d)",
                 n_checked, n_ok, n_zero, n_fell);
        $display("sender held back for the pipeline to empty %0d times", n_drains);
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/nrdiv_pkg.sv
design/nrdiv_ctrl.sv
design/nrdiv_dp.sv
design/newton_reciprocal_integer_divider_top.sv
test/testbench.sv
